### rtl/iibb_pkg.sv
package iibb_pkg;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int SUM_W      = 22;
    localparam int RUN_W      = 15;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 24;
    localparam int SCALE_W    = 14;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;
    localparam logic [1:0] REG_DIVISOR = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LD_RD, ST_LD_WR, ST_SCALE, ST_DIV, ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
        ST_CH, ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
        logic [SCALE_W:0] scale;
    } div_req_t;
endpackage

### rtl/integral_image_box_blur.sv
// Load: each item passes through transfer, read of the entry above and write back; no result.
// Query: after the input transfer come the scale division (side^2 by divisor), the four
// corner reads and the sum, and the per-channel division; each division is a 22-step
// bit-serial divider. The next transfer is taken only once the result has been accepted.
// One item in flight.
// Synchronous active-low reset: registers 128/128/2/1, load position and row totals zero.
module integral_image_box_blur (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [14:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [23:0]                 s_pixel_in,
    input  logic [6:0]                  s_query_x,
    input  logic [6:0]                  s_query_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [23:0]                 m_blurred_pixel
);
    import iibb_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]  width_reg, height_reg;
    logic [5:0]  radius_reg;
    logic [14:0] divisor_reg;
    logic [RUN_W-1:0] run_reg [3];
    logic [COL_W-1:0] lcol_reg;
    logic [ROW_W-1:0] lrow_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [SUM_W-1:0] acc_reg [3];
    logic [PIX_W-1:0] out_reg;
    logic             out_valid_reg;
    logic [SCALE_W:0] scale_reg;
    logic signed [9:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic             corner_ok_reg;
    logic             corner_neg_reg;
    logic             above_ok_reg;

    logic [7:0] w_eff, h_eff;
    assign w_eff = (width_reg == '0) ? 8'd1 : (width_reg > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH)
                 : width_reg;
    assign h_eff = (height_reg == '0) ? 8'd1 : (height_reg > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT)
                 : height_reg;

    // memories
    logic             ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [SUM_W-1:0] ram_wd [3];
    logic [SUM_W-1:0] ram_rd [3];
    for (genvar c = 0; c < 3; c++) begin : g_ram
        iibb_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
            .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd[c]), .rdata(ram_rd[c])
        );
    end

    // divider shared for scale and channels
    div_req_t dreq;
    logic     ddone;
    logic [3*SUM_W-1:0] dquot;
    logic [SUM_W-1:0]   dq [3];
    iibb_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dquot));
    assign dq[0] = dquot[3*SUM_W-1 -: SUM_W];
    assign dq[1] = dquot[2*SUM_W-1 -: SUM_W];
    assign dq[2] = dquot[SUM_W-1:0];

    // corner selection: (x2,y2) and (x1,y1) add, (x1,y2) and (x2,y1) subtract
    logic signed [9:0] cx, cy;
    logic              corner_ok;
    logic [ADDR_W-1:0] corner_addr;
    always_comb begin
        case (state_reg)
            ST_Q1: begin cx = x1_reg; cy = y1_reg; end
            ST_Q2: begin cx = x1_reg; cy = y2_reg; end
            ST_Q3: begin cx = x2_reg; cy = y1_reg; end
            default: begin cx = x2_reg; cy = y2_reg; end
        endcase
    end
    // a negative coordinate reads as zero
    assign corner_ok = (cx >= 10'sd0) && (cy >= 10'sd0);
    assign corner_addr = {cy[ROW_W-1:0], cx[COL_W-1:0]};

    logic [7:0] pch [3];
    assign pch[0] = pix_reg[23:16];
    assign pch[1] = pix_reg[15:8];
    assign pch[2] = pix_reg[7:0];
    logic [RUN_W-1:0] run_new [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            run_new[c] = run_reg[c] + RUN_W'(pch[c]);
            ram_wd[c] = SUM_W'(run_new[c]) + (above_ok_reg ? ram_rd[c] : '0);
        end
    end

    logic signed [9:0] qx, qy, kk;
    assign qx = 10'(s_query_x);
    assign qy = 10'(s_query_y);
    assign kk = 10'(radius_reg);
    function automatic logic signed [9:0] clamp_hi(logic signed [9:0] v, logic [7:0] n);
        logic signed [9:0] last;
        last = 10'(n) - 10'sd1;
        return (v > last) ? last : v;
    endfunction
    logic [13:0] side_sq;
    logic [13:0] side;
    assign side = {7'd0, radius_reg, 1'b1};
    assign side_sq = side * side;

    function automatic logic [CH_W-1:0] cap_chan(logic [SUM_W-1:0] q, logic zero_scale);
        if (zero_scale || q > SUM_W'(255)) return '1;
        return q[CH_W-1:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        ram_we = 1'b0;
        ram_addr = {lrow_reg - ROW_W'(1), lcol_reg};
        dreq = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready)
                    state_next = (s_operation == OP_LOAD) ? ST_LD_RD : ST_SCALE;
            end
            ST_LD_RD: state_next = ST_LD_WR;
            ST_LD_WR: begin
                ram_addr = {lrow_reg, lcol_reg};
                ram_we = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCALE: begin
                dreq.start = 1'b1;
                dreq.r = SUM_W'(side_sq);
                dreq.scale = divisor_reg;
                state_next = ST_DIV;
            end
            ST_DIV: if (ddone) state_next = ST_Q0;
            ST_Q0: begin
                ram_addr = corner_addr;
                state_next = ST_Q1;
            end
            ST_Q1: begin
                ram_addr = corner_addr;
                state_next = ST_Q2;
            end
            ST_Q2: begin
                ram_addr = corner_addr;
                state_next = ST_Q3;
            end
            ST_Q3: begin
                ram_addr = corner_addr;
                state_next = ST_Q4;
            end
            ST_Q4: state_next = ST_CH;
            ST_CH: begin
                dreq.start = 1'b1;
                dreq.r = acc_reg[0];
                dreq.g = acc_reg[1];
                dreq.b = acc_reg[2];
                dreq.scale = scale_reg;
                state_next = ST_OUT;
            end
            ST_OUT: if (ddone) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_blurred_pixel = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            width_reg <= 8'd128;
            height_reg <= 8'd128;
            radius_reg <= 6'd2;
            divisor_reg <= 15'd1;
            for (int c = 0; c < 3; c++) run_reg[c] <= '0;
            lcol_reg <= '0;
            lrow_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH:   width_reg <= cfg_data[7:0];
                    REG_HEIGHT:  height_reg <= cfg_data[7:0];
                    REG_RADIUS:  radius_reg <= cfg_data[5:0];
                    REG_DIVISOR: divisor_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && ddone) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    // load position outside a shrunken image restarts at the origin
                    if (s_operation == OP_LOAD &&
                        (8'(lcol_reg) >= w_eff || 8'(lrow_reg) >= h_eff)) begin
                        lcol_reg <= '0;
                        lrow_reg <= '0;
                        for (int c = 0; c < 3; c++) run_reg[c] <= '0;
                    end
                end
                ST_LD_WR: begin
                    if (8'(lcol_reg) + 8'd1 >= w_eff) begin
                        lcol_reg <= '0;
                        for (int c = 0; c < 3; c++) run_reg[c] <= '0;
                        lrow_reg <= (8'(lrow_reg) + 8'd1 >= h_eff) ? '0 : lrow_reg + ROW_W'(1);
                    end else begin
                        lcol_reg <= lcol_reg + COL_W'(1);
                        for (int c = 0; c < 3; c++) run_reg[c] <= run_new[c];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                pix_reg <= s_pixel_in;
                x1_reg <= clamp_hi(qx - kk - 10'sd1, w_eff);
                y1_reg <= clamp_hi(qy - kk - 10'sd1, h_eff);
                x2_reg <= clamp_hi(qx + kk, w_eff);
                y2_reg <= clamp_hi(qy + kk, h_eff);
            end
            ST_LD_RD: above_ok_reg <= (lrow_reg != '0);
            ST_DIV: if (ddone) begin
                scale_reg <= (divisor_reg == '0) ? '0 : {1'b0, dq[0][SCALE_W-1:0]};
            end
            ST_OUT: if (ddone) begin
                out_reg <= {cap_chan(dq[0], scale_reg == '0), cap_chan(dq[1], scale_reg == '0),
                            cap_chan(dq[2], scale_reg == '0)};
            end
            default: ;
        endcase
        // read data of a corner arrives in the cycle after its address
        if (state_reg inside {ST_Q0, ST_Q1, ST_Q2, ST_Q3}) begin
            corner_ok_reg <= corner_ok;
            corner_neg_reg <= state_reg inside {ST_Q2, ST_Q3};
        end
        if (state_reg == ST_Q0) begin
            for (int c = 0; c < 3; c++) acc_reg[c] <= '0;
        end else if (state_reg inside {ST_Q1, ST_Q2, ST_Q3, ST_Q4}) begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= corner_ok_reg ?
                    (corner_neg_reg ? acc_reg[c] - ram_rd[c] : acc_reg[c] + ram_rd[c])
                    : acc_reg[c];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid)
        else $error("accept while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LD_WR |=> state_reg == ST_IDLE)
        else $error("load sequence broken");
    assert property (@(posedge aclk) disable iff (!aresetn) ram_we |-> state_reg == ST_LD_WR)
        else $error("table write outside load");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blurred_pixel))
        else $error("result dropped or changed while waiting");
endmodule

### rtl/iibb_ram.sv
module iibb_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/iibb_div.sv
module iibb_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  iibb_pkg::div_req_t           req,
    output logic                         done,
    output logic [3*iibb_pkg::SUM_W-1:0] quot
);
    import iibb_pkg::*;

    // restoring divider, one quotient bit per cycle, three channels in parallel
    logic [SUM_W-1:0]   num_reg [3];
    logic [SUM_W-1:0]   rem_reg [3];
    logic [SCALE_W:0]   den_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                num_reg[0] <= req.r;
                num_reg[1] <= req.g;
                num_reg[2] <= req.b;
                for (int i = 0; i < 3; i++) rem_reg[i] <= '0;
                den_reg  <= req.scale;
                cnt_reg  <= 5'(SUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        logic [SUM_W:0] t;
                        t = {rem_reg[i], num_reg[i][SUM_W-1]};
                        if (t >= (SUM_W+1)'(den_reg)) begin
                            rem_reg[i] <= SUM_W'(t - (SUM_W+1)'(den_reg));
                            num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b1};
                        end else begin
                            rem_reg[i] <= t[SUM_W-1:0];
                            num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    // quotients sit in the numerator registers once the shifting is over
    assign done = done_reg;
    assign quot = {num_reg[0], num_reg[1], num_reg[2]};

    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !req.start && cnt_reg != '0 |=> busy_reg)
        else $error("divider stopped early");
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |=> busy_reg)
        else $error("divider did not start");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import iibb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [14:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_LOAD;
    logic [23:0] s_pixel_in = '0;
    logic [6:0]  s_query_x = '0;
    logic [6:0]  s_query_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_blurred_pixel;

    integral_image_box_blur dut (.*);

    always #1 aclk = ~aclk;

    typedef struct packed {
        logic        op;
        logic [23:0] pixel;
        logic [6:0]  qx;
        logic [6:0]  qy;
    } blur_item_t;

    // blur model state
    logic [21:0] sat_r [DEPTH];
    logic [21:0] sat_g [DEPTH];
    logic [21:0] sat_b [DEPTH];
    logic [14:0] run_r, run_g, run_b;
    int          ld_col, ld_row;
    logic [7:0]  img_w, img_h;
    logic [5:0]  radius;
    logic [14:0] divisor;

    blur_item_t  pending_items[$];
    logic [23:0] expected_pixels[$];
    int          errors = 0;
    int          sent = 0;
    longint      cycles = 0;
    logic        accepted = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    function automatic int eff(input logic [7:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [21:0] sat_at(input int ch, input int c, input int r);
        if (c < 0 || r < 0) return '0;
        case (ch)
            0: return sat_r[r*MAX_WIDTH+c];
            1: return sat_g[r*MAX_WIDTH+c];
            default: return sat_b[r*MAX_WIDTH+c];
        endcase
    endfunction

    function automatic logic [7:0] scaled(input logic [21:0] s, input int unsigned sc);
        int unsigned v;
        if (sc == 0) return 8'hff;
        v = s / sc;
        return v > 255 ? 8'hff : v[7:0];
    endfunction

    task automatic predict_blur(input blur_item_t it);
        int w, h, x1, y1, x2, y2, k, at;
        int unsigned side, sc;
        logic [21:0] s;
        logic [23:0] res;
        w = eff(img_w, MAX_WIDTH);
        h = eff(img_h, MAX_HEIGHT);
        if (it.op == OP_LOAD) begin
            if (ld_col >= w || ld_row >= h) begin
                ld_col = 0; ld_row = 0; run_r = 0; run_g = 0; run_b = 0;
            end
            run_r = run_r + it.pixel[23:16];
            run_g = run_g + it.pixel[15:8];
            run_b = run_b + it.pixel[7:0];
            at = ld_row * MAX_WIDTH + ld_col;
            sat_r[at] = run_r + sat_at(0, ld_col, ld_row - 1);
            sat_g[at] = run_g + sat_at(1, ld_col, ld_row - 1);
            sat_b[at] = run_b + sat_at(2, ld_col, ld_row - 1);
            if (ld_col + 1 >= w) begin
                ld_col = 0; run_r = 0; run_g = 0; run_b = 0;
                ld_row = (ld_row + 1 >= h) ? 0 : ld_row + 1;
            end else begin
                ld_col++;
            end
        end else begin
            k = radius;
            x1 = it.qx - k - 1; if (x1 > w - 1) x1 = w - 1;
            y1 = it.qy - k - 1; if (y1 > h - 1) y1 = h - 1;
            x2 = it.qx + k;     if (x2 > w - 1) x2 = w - 1;
            y2 = it.qy + k;     if (y2 > h - 1) y2 = h - 1;
            side = 2 * k + 1;
            sc = divisor ? (side * side) / divisor : 0;
            for (int ch = 0; ch < 3; ch++) begin
                s = sat_at(ch, x2, y2) + sat_at(ch, x1, y1) - sat_at(ch, x1, y2)
                    - sat_at(ch, x2, y1);
                res[23-8*ch -: 8] = scaled(s, sc);
            end
            expected_pixels.push_back(res);
        end
    endtask

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (!s_valid || accepted) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                blur_item_t it;
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_operation <= it.op;
                s_pixel_in <= it.pixel;
                s_query_x <= it.qx;
                s_query_y <= it.qy;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // acceptance sampled at the rising edge; model updated there too
    always @(posedge aclk) begin
        accepted <= 1'b0;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) begin
            accepted <= 1'b1;
            predict_blur(blur_item_t'{s_operation, s_pixel_in, s_query_x, s_query_y});
            sent <= sent + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_blurred_pixel));
            else begin
                logic [23:0] e;
                e = expected_pixels.pop_front();
                if (e !== m_blurred_pixel)
                    report_mismatch($sformatf("blurred_pixel %h, want %h",
                        m_blurred_pixel, e));
            end
        end
        if (cycles > 3000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 79) == 0);
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = val[7:0];
            REG_HEIGHT: img_h = val[7:0];
            REG_RADIUS: radius = val[5:0];
            default:    divisor = val;
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_items.size() > 0 || s_valid || expected_pixels.size() > 0)
               && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    // full image load, then queries anywhere (all entries written)
    task automatic image_phase(input int w, input int h, input int nq, input bit extremes);
        blur_item_t it;
        for (int i = 0; i < w * h; i++) begin
            it = '{OP_LOAD, 24'($urandom), 7'($urandom), 7'($urandom)};
            if (extremes) it.pixel = (i % 3 == 0) ? 24'hffffff : (i % 3 == 1 ? 24'h0 : it.pixel);
            pending_items.push_back(it);
        end
        for (int i = 0; i < nq; i++) begin
            it = '{OP_QUERY, 24'($urandom), 7'($urandom), 7'($urandom)};
            if ($urandom_range(0, 1)) begin
                it.qx = $urandom_range(0, w - 1);
                it.qy = $urandom_range(0, h - 1);
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        run_r = 0; run_g = 0; run_b = 0; ld_col = 0; ld_row = 0;
        img_w = 128; img_h = 128; radius = 2; divisor = 1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: tiny image, corners, extremes, zero scale
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_RADIUS, 0);
        write_reg(REG_DIVISOR, 1);
        image_phase(3, 2, 0, 1);
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd0, 7'd0});
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'hffffff, 7'd2, 7'd1});
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd127, 7'd127});
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd1, 7'd0});
        drain();
        write_reg(REG_RADIUS, 63);
        write_reg(REG_DIVISOR, 15'h7fff);
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd1, 7'd1});
        drain();
        write_reg(REG_DIVISOR, 0);
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd0, 7'd1});
        drain();
        write_reg(REG_DIVISOR, 16384);
        pending_items.push_back(blur_item_t'{OP_QUERY, 24'h0, 7'd2, 7'd0});
        drain();

        // shrink in the middle of an image: the next load restarts at the origin
        write_reg(REG_RADIUS, 1);
        write_reg(REG_DIVISOR, 2);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(blur_item_t'{OP_LOAD, 24'($urandom), 7'd0, 7'd0});
        drain();
        write_reg(REG_HEIGHT, 1);
        image_phase(3, 1, 6, 0);
        drain();

        // random phases
        for (int p = 0; p < 14; p++) begin
            int w, h;
            w = (p == 13) ? 128 : $urandom_range(1, 12);
            h = (p == 13) ? 4 : $urandom_range(1, 10);
            write_reg(REG_WIDTH, (p == 5) ? 0 : w);
            write_reg(REG_HEIGHT, (p == 6) ? 255 : h);
            if (p == 5) w = 1;
            if (p == 6) h = 128;
            if (p == 6) w = 1;
            if (p == 6) write_reg(REG_WIDTH, 1);
            write_reg(REG_RADIUS, (p % 4 == 0) ? 63 : $urandom_range(0, 5));
            write_reg(REG_DIVISOR, (p % 5 == 0) ? 16384 : $urandom_range(1, 30));
            image_phase(w, h, 50, 0);
            drain();
        end

        drain();
        if (pending_items.size() != 0)
            report_mismatch($sformatf("%0d items never sent", pending_items.size()));
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results missing", expected_pixels.size()));
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### integral_image_box_blur.f
rtl/iibb_pkg.sv
rtl/iibb_ram.sv
rtl/iibb_div.sv
rtl/integral_image_box_blur.sv
tb/tb.sv
